### hw/rtl/jvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jvc_pkg;

    // Datapath widths
    localparam int RAW_W  = 16;
    localparam int MAG_W  = 16;
    localparam int MAX_W  = 16;
    localparam int W_W    = 17;
    localparam int VEL_W  = 26;   // Q20 velocity, |v| < 2^25
    localparam int HGT_W  = 30;   // Q28 height, unsigned
    localparam int TGT_W  = 14;   // Q12 height target
    localparam int S_W    = 31;   // sample / filter operand
    localparam int DIFF_W = 32;
    localparam int MA_W   = 32;   // multiplier operand A
    localparam int MB_W   = 18;   // multiplier operand B
    localparam int PROD_W = MA_W + MB_W;
    localparam int X_W    = 40;   // biased dividend
    localparam int Q_W    = 25;
    localparam int REM_W  = 26;
    localparam int STEP_W = 6;
    localparam int DATA_IN_W  = 24;
    localparam int DATA_OUT_W = 64;

    // Divide by full-scale deflection
    localparam logic [REM_W-1:0] DIV_N    = REM_W'(32767);
    localparam logic [X_W-1:0]   DIV_BIAS = X_W'(16383);

    // Height limits and step, Q12
    localparam logic [TGT_W-1:0] HEIGHT_LOW  = TGT_W'(4096);
    localparam logic [TGT_W-1:0] HEIGHT_HIGH = TGT_W'(12288);
    localparam logic [TGT_W-1:0] HEIGHT_STEP = TGT_W'(819);
    localparam logic [HGT_W-1:0] HGT_ONE     = HGT_W'(32'h1000_0000);

    // Commands
    localparam logic [1:0] CMD_AXIS   = 2'd0;
    localparam logic [1:0] CMD_BUTTON = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Axis and button numbers
    localparam logic [7:0] AXIS_FWD  = 8'd4;
    localparam logic [7:0] AXIS_LAT  = 8'd0;
    localparam logic [7:0] AXIS_TURN = 8'd6;
    localparam logic [7:0] BTN_A     = 8'd0;
    localparam logic [7:0] BTN_B     = 8'd1;
    localparam logic [7:0] BTN_X     = 8'd2;
    localparam logic [7:0] BTN_Y     = 8'd3;
    localparam logic [7:0] BTN_DOWN  = 8'd6;
    localparam logic [7:0] BTN_UP    = 8'd7;
    localparam logic [7:0] BTN_START = 8'd9;
    localparam logic [7:0] BTN_STOP  = 8'd10;

    // Register indexes
    localparam logic [2:0] REG_DEAD_ZONE = 3'd0;
    localparam logic [2:0] REG_FWD_MAX   = 3'd1;
    localparam logic [2:0] REG_REV_MAX   = 3'd2;
    localparam logic [2:0] REG_LAT_MAX   = 3'd3;
    localparam logic [2:0] REG_TURN_MAX  = 3'd4;
    localparam logic [2:0] REG_SM_PLANAR = 3'd5;
    localparam logic [2:0] REG_SM_TURN   = 3'd6;
    localparam logic [2:0] REG_SM_HEIGHT = 3'd7;

    // Register reset values
    localparam logic [14:0]      RST_DEAD_ZONE = 15'd1000;
    localparam logic [MAX_W-1:0] RST_FWD_MAX   = 16'd32768;
    localparam logic [MAX_W-1:0] RST_REV_MAX   = 16'd8192;
    localparam logic [MAX_W-1:0] RST_LAT_MAX   = 16'd2458;
    localparam logic [MAX_W-1:0] RST_TURN_MAX  = 16'd6144;
    localparam logic [W_W-1:0]   RST_SM_PLANAR = 17'd1966;
    localparam logic [W_W-1:0]   RST_SM_TURN   = 17'd3277;
    localparam logic [W_W-1:0]   RST_SM_HEIGHT = 17'd6554;

    // Filter channels
    localparam logic [1:0] CH_FWD  = 2'd0;
    localparam logic [1:0] CH_LAT  = 2'd1;
    localparam logic [1:0] CH_TURN = 2'd2;
    localparam logic [1:0] CH_HGT  = 2'd3;

    typedef struct packed {
        logic [14:0]      dead_zone;
        logic [MAX_W-1:0] fwd_max;
        logic [MAX_W-1:0] rev_max;
        logic [MAX_W-1:0] lat_max;
        logic [MAX_W-1:0] turn_max;
        logic [W_W-1:0]   sm_planar;
        logic [W_W-1:0]   sm_turn;
        logic [W_W-1:0]   sm_height;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,    // magnitude, sign, max select
        OP_ZERO,    // sample = 0 (dead zone path)
        OP_MULA,    // mag * max
        OP_BIAS,    // prod * 256 + rounding bias
        OP_FOLD1,   // first fold of the /32767
        OP_FOLD2,   // second fold
        OP_FIX,     // final compare-subtract
        OP_SIGN,    // apply sign to quotient
        OP_HTGT,    // sample = target << 16
        OP_DIFF,    // sample - filter
        OP_MULF,    // weight * diff
        OP_UPD,     // filter += rounded product
        OP_OUT      // round, saturate, load output register
    } t_op;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_DZ,
        COND_ALWAYS
    } t_cond;

    typedef struct packed {
        t_op              op;
        logic [1:0]       ch;
        t_cond            cond;
        logic [STEP_W-1:0] tgt;
        logic             last;
    } t_uword;

    typedef struct packed {
        logic dead_zone;
        logic out_free;
    } t_dp_stat;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Jump targets
    localparam logic [STEP_W-1:0] ST_FWD_DIFF  = 6'd8;
    localparam logic [STEP_W-1:0] ST_LAT_DIFF  = 6'd19;
    localparam logic [STEP_W-1:0] ST_TURN_DIFF = 6'd30;
    localparam logic [STEP_W-1:0] ST_NONE      = 6'd0;

    function automatic t_uword f_uw(t_op op, logic [1:0] ch, t_cond cond,
                                    logic [STEP_W-1:0] tgt, logic last);
        t_uword w;
        w.op   = op;
        w.ch   = ch;
        w.cond = cond;
        w.tgt  = tgt;
        w.last = last;
        return w;
    endfunction

    // Tick program: three axis channels, the height filter, then the output.
    function automatic t_uword f_ucode(logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            6'd0:  w = f_uw(OP_LOAD,  CH_FWD,  COND_NONE, ST_NONE,     1'b0);
            6'd1:  w = f_uw(OP_ZERO,  CH_FWD,  COND_DZ,   ST_FWD_DIFF, 1'b0);
            6'd2:  w = f_uw(OP_MULA,  CH_FWD,  COND_NONE, ST_NONE,     1'b0);
            6'd3:  w = f_uw(OP_BIAS,  CH_FWD,  COND_NONE, ST_NONE,     1'b0);
            6'd4:  w = f_uw(OP_FOLD1, CH_FWD,  COND_NONE, ST_NONE,     1'b0);
            6'd5:  w = f_uw(OP_FOLD2, CH_FWD,  COND_NONE, ST_NONE,     1'b0);
            6'd6:  w = f_uw(OP_FIX,   CH_FWD,  COND_NONE, ST_NONE,     1'b0);
            6'd7:  w = f_uw(OP_SIGN,  CH_FWD,  COND_NONE, ST_NONE,     1'b0);
            6'd8:  w = f_uw(OP_DIFF,  CH_FWD,  COND_NONE, ST_NONE,     1'b0);
            6'd9:  w = f_uw(OP_MULF,  CH_FWD,  COND_NONE, ST_NONE,     1'b0);
            6'd10: w = f_uw(OP_UPD,   CH_FWD,  COND_NONE, ST_NONE,     1'b0);
            6'd11: w = f_uw(OP_LOAD,  CH_LAT,  COND_NONE, ST_NONE,     1'b0);
            6'd12: w = f_uw(OP_ZERO,  CH_LAT,  COND_DZ,   ST_LAT_DIFF, 1'b0);
            6'd13: w = f_uw(OP_MULA,  CH_LAT,  COND_NONE, ST_NONE,     1'b0);
            6'd14: w = f_uw(OP_BIAS,  CH_LAT,  COND_NONE, ST_NONE,     1'b0);
            6'd15: w = f_uw(OP_FOLD1, CH_LAT,  COND_NONE, ST_NONE,     1'b0);
            6'd16: w = f_uw(OP_FOLD2, CH_LAT,  COND_NONE, ST_NONE,     1'b0);
            6'd17: w = f_uw(OP_FIX,   CH_LAT,  COND_NONE, ST_NONE,     1'b0);
            6'd18: w = f_uw(OP_SIGN,  CH_LAT,  COND_NONE, ST_NONE,     1'b0);
            6'd19: w = f_uw(OP_DIFF,  CH_LAT,  COND_NONE, ST_NONE,     1'b0);
            6'd20: w = f_uw(OP_MULF,  CH_LAT,  COND_NONE, ST_NONE,     1'b0);
            6'd21: w = f_uw(OP_UPD,   CH_LAT,  COND_NONE, ST_NONE,     1'b0);
            6'd22: w = f_uw(OP_LOAD,  CH_TURN, COND_NONE, ST_NONE,     1'b0);
            6'd23: w = f_uw(OP_ZERO,  CH_TURN, COND_DZ,   ST_TURN_DIFF, 1'b0);
            6'd24: w = f_uw(OP_MULA,  CH_TURN, COND_NONE, ST_NONE,     1'b0);
            6'd25: w = f_uw(OP_BIAS,  CH_TURN, COND_NONE, ST_NONE,     1'b0);
            6'd26: w = f_uw(OP_FOLD1, CH_TURN, COND_NONE, ST_NONE,     1'b0);
            6'd27: w = f_uw(OP_FOLD2, CH_TURN, COND_NONE, ST_NONE,     1'b0);
            6'd28: w = f_uw(OP_FIX,   CH_TURN, COND_NONE, ST_NONE,     1'b0);
            6'd29: w = f_uw(OP_SIGN,  CH_TURN, COND_NONE, ST_NONE,     1'b0);
            6'd30: w = f_uw(OP_DIFF,  CH_TURN, COND_NONE, ST_NONE,     1'b0);
            6'd31: w = f_uw(OP_MULF,  CH_TURN, COND_NONE, ST_NONE,     1'b0);
            6'd32: w = f_uw(OP_UPD,   CH_TURN, COND_NONE, ST_NONE,     1'b0);
            6'd33: w = f_uw(OP_HTGT,  CH_HGT,  COND_NONE, ST_NONE,     1'b0);
            6'd34: w = f_uw(OP_DIFF,  CH_HGT,  COND_NONE, ST_NONE,     1'b0);
            6'd35: w = f_uw(OP_MULF,  CH_HGT,  COND_NONE, ST_NONE,     1'b0);
            6'd36: w = f_uw(OP_UPD,   CH_HGT,  COND_NONE, ST_NONE,     1'b0);
            6'd37: w = f_uw(OP_OUT,   CH_HGT,  COND_NONE, ST_NONE,     1'b1);
            default: w = f_uw(OP_NOP, CH_FWD,  COND_NONE, ST_NONE,     1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/jvc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module jvc_cfg_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output jvc_pkg::t_cfg    o_cfg
);

    jvc_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_zone <= jvc_pkg::RST_DEAD_ZONE;
            r_cfg.fwd_max   <= jvc_pkg::RST_FWD_MAX;
            r_cfg.rev_max   <= jvc_pkg::RST_REV_MAX;
            r_cfg.lat_max   <= jvc_pkg::RST_LAT_MAX;
            r_cfg.turn_max  <= jvc_pkg::RST_TURN_MAX;
            r_cfg.sm_planar <= jvc_pkg::RST_SM_PLANAR;
            r_cfg.sm_turn   <= jvc_pkg::RST_SM_TURN;
            r_cfg.sm_height <= jvc_pkg::RST_SM_HEIGHT;
        end else if (wr_en) begin
            case (paddr[4:2])
                jvc_pkg::REG_DEAD_ZONE: r_cfg.dead_zone <= pwdata[14:0];
                jvc_pkg::REG_FWD_MAX:   r_cfg.fwd_max   <= pwdata[15:0];
                jvc_pkg::REG_REV_MAX:   r_cfg.rev_max   <= pwdata[15:0];
                jvc_pkg::REG_LAT_MAX:   r_cfg.lat_max   <= pwdata[15:0];
                jvc_pkg::REG_TURN_MAX:  r_cfg.turn_max  <= pwdata[15:0];
                jvc_pkg::REG_SM_PLANAR: r_cfg.sm_planar <= pwdata[16:0];
                jvc_pkg::REG_SM_TURN:   r_cfg.sm_turn   <= pwdata[16:0];
                jvc_pkg::REG_SM_HEIGHT: r_cfg.sm_height <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            jvc_pkg::REG_DEAD_ZONE: prdata = {17'd0, r_cfg.dead_zone};
            jvc_pkg::REG_FWD_MAX:   prdata = {16'd0, r_cfg.fwd_max};
            jvc_pkg::REG_REV_MAX:   prdata = {16'd0, r_cfg.rev_max};
            jvc_pkg::REG_LAT_MAX:   prdata = {16'd0, r_cfg.lat_max};
            jvc_pkg::REG_TURN_MAX:  prdata = {16'd0, r_cfg.turn_max};
            jvc_pkg::REG_SM_PLANAR: prdata = {15'd0, r_cfg.sm_planar};
            jvc_pkg::REG_SM_TURN:   prdata = {15'd0, r_cfg.sm_turn};
            jvc_pkg::REG_SM_HEIGHT: prdata = {15'd0, r_cfg.sm_height};
            default:                prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/jvc_useq.sv
`timescale 1ns / 1ps
`default_nettype none

module jvc_useq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire jvc_pkg::t_dp_stat i_stat,
    output logic                  o_ready,
    output jvc_pkg::t_uword       o_ctl
);

    jvc_pkg::t_seq_state               r_state, n_state;
    logic [jvc_pkg::STEP_W-1:0]        r_step, n_step;
    jvc_pkg::t_uword                   uw;
    logic                              hold;
    logic                              jump;

    assign uw   = jvc_pkg::f_ucode(r_step);
    // output step waits for a free output register
    assign hold = (uw.op == jvc_pkg::OP_OUT) && !i_stat.out_free;

    always_comb begin
        case (uw.cond)
            jvc_pkg::COND_DZ:     jump = i_stat.dead_zone;
            jvc_pkg::COND_ALWAYS: jump = 1'b1;
            default:              jump = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jvc_pkg::SEQ_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            jvc_pkg::SEQ_IDLE: begin
                n_step = '0;
                if (i_start) begin
                    n_state = jvc_pkg::SEQ_RUN;
                end
            end
            jvc_pkg::SEQ_RUN: begin
                if (hold) begin
                    n_step = r_step;
                end else if (uw.last) begin
                    n_state = jvc_pkg::SEQ_IDLE;
                    n_step  = '0;
                end else if (jump) begin
                    n_step = uw.tgt;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
                n_state = jvc_pkg::SEQ_IDLE;
                n_step  = '0;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready = 1'b0;
        o_ctl   = uw;
        case (r_state)
            jvc_pkg::SEQ_IDLE: begin
                o_ready  = 1'b1;
                o_ctl.op = jvc_pkg::OP_NOP;
            end
            jvc_pkg::SEQ_RUN: begin
                o_ready = 1'b0;
            end
            default: begin
                o_ctl.op = jvc_pkg::OP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/jvc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module jvc_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire jvc_pkg::t_cfg        i_cfg,
    input  wire jvc_pkg::t_uword      i_ctl,
    output jvc_pkg::t_dp_stat         o_stat,
    input  wire logic                 i_evt_acc,
    input  wire logic [1:0]           i_evt_cmd,
    input  wire logic [7:0]           i_evt_num,
    input  wire logic signed [15:0]   i_evt_val,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [jvc_pkg::DATA_OUT_W-1:0] o_out_data
);

    localparam int VW = jvc_pkg::VEL_W;
    localparam int HW = jvc_pkg::HGT_W;
    localparam int SW = jvc_pkg::S_W;

    // architectural state
    logic signed [jvc_pkg::RAW_W-1:0]  r_raw [3];
    logic signed [VW-1:0]              r_vel [3];
    logic [HW-1:0]                     r_hgt;
    logic [jvc_pkg::TGT_W-1:0]         r_htgt;
    logic [3:0]                        r_flags;

    // working registers
    logic [jvc_pkg::MAG_W-1:0]         r_mag;
    logic                              r_neg;
    logic [jvc_pkg::MAX_W-1:0]         r_max;
    logic signed [jvc_pkg::PROD_W-1:0] r_prod;
    logic [jvc_pkg::X_W-1:0]           r_x;
    logic [jvc_pkg::Q_W-1:0]           r_q;
    logic [jvc_pkg::REM_W-1:0]         r_rem;
    logic signed [SW-1:0]              r_s;
    logic signed [jvc_pkg::DIFF_W-1:0] r_diff;

    logic                              r_out_valid;
    logic [jvc_pkg::DATA_OUT_W-1:0]    r_out_data;

    logic signed [jvc_pkg::RAW_W-1:0]  raw_sel;
    logic signed [SW-1:0]              f_sel;
    logic [jvc_pkg::W_W-1:0]           w_sel;
    logic [jvc_pkg::W_W-1:0]           w_lim;
    logic signed [jvc_pkg::MA_W-1:0]   mul_a;
    logic signed [jvc_pkg::MB_W-1:0]   mul_b;
    logic signed [jvc_pkg::PROD_W-1:0] mul_p;
    logic signed [jvc_pkg::PROD_W-1:0] rnd_sum;
    logic signed [SW+2:0]              upd;
    logic signed [SW-1:0]              q_s;
    logic                              out_free;
    logic                              btn_press;

    logic signed [VW:0]                fw_sum, lt_sum, yw_sum;
    logic signed [VW-8:0]              fw_r, lt_r, yw_r;
    logic signed [16:0]                fw_o;
    logic signed [12:0]                lt_o;
    logic signed [13:0]                yw_o;
    logic [HW:0]                       ht_sum;
    logic [HW-16:0]                    ht_r;
    logic [13:0]                       ht_o;

    assign out_free        = !r_out_valid || i_out_ready;
    assign o_stat.out_free = out_free;
    assign o_stat.dead_zone = (r_mag <= {1'b0, i_cfg.dead_zone});
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign btn_press       = (i_evt_val != '0);

    // channel operand selection
    always_comb begin
        case (i_ctl.ch)
            jvc_pkg::CH_FWD: begin
                raw_sel = r_raw[0];
                f_sel   = {{(SW-VW){r_vel[0][VW-1]}}, r_vel[0]};
                w_sel   = i_cfg.sm_planar;
            end
            jvc_pkg::CH_LAT: begin
                raw_sel = r_raw[1];
                f_sel   = {{(SW-VW){r_vel[1][VW-1]}}, r_vel[1]};
                w_sel   = i_cfg.sm_planar;
            end
            jvc_pkg::CH_TURN: begin
                raw_sel = r_raw[2];
                f_sel   = {{(SW-VW){r_vel[2][VW-1]}}, r_vel[2]};
                w_sel   = i_cfg.sm_turn;
            end
            default: begin
                raw_sel = '0;
                f_sel   = $signed({1'b0, r_hgt});
                w_sel   = i_cfg.sm_height;
            end
        endcase
    end

    // weights above 1.0 act as 1.0
    assign w_lim = w_sel[jvc_pkg::W_W-1] ? {1'b1, {(jvc_pkg::W_W-1){1'b0}}} : w_sel;

    // shared multiplier
    always_comb begin
        case (i_ctl.op)
            jvc_pkg::OP_MULA: begin
                mul_a = $signed({{(jvc_pkg::MA_W-jvc_pkg::MAG_W){1'b0}}, r_mag});
                mul_b = $signed({{(jvc_pkg::MB_W-jvc_pkg::MAX_W){1'b0}}, r_max});
            end
            default: begin
                mul_a = r_diff;
                mul_b = $signed({1'b0, w_lim});
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // f + floor((w*(s-f) + 2^15) / 2^16)
    assign rnd_sum = r_prod + $signed(jvc_pkg::PROD_W'(32768));
    assign upd     = {{3{f_sel[SW-1]}}, f_sel} + rnd_sum[jvc_pkg::PROD_W-1:16];
    assign q_s     = $signed({{(SW-jvc_pkg::Q_W){1'b0}}, r_q});

    // Q20 -> Q12 and Q28 -> Q12, half up, then clamp
    always_comb begin
        fw_sum = {r_vel[0][VW-1], r_vel[0]} + (VW+1)'(128);
        lt_sum = {r_vel[1][VW-1], r_vel[1]} + (VW+1)'(128);
        yw_sum = {r_vel[2][VW-1], r_vel[2]} + (VW+1)'(128);
        fw_r   = fw_sum[VW:8];
        lt_r   = lt_sum[VW:8];
        yw_r   = yw_sum[VW:8];

        if (fw_r < -(VW-7)'(8192))      fw_o = -17'sd8192;
        else if (fw_r > (VW-7)'(32768)) fw_o = 17'sd32768;
        else                            fw_o = fw_r[16:0];

        if (lt_r < -(VW-7)'(2458))      lt_o = -13'sd2458;
        else if (lt_r > (VW-7)'(2458))  lt_o = 13'sd2458;
        else                            lt_o = lt_r[12:0];

        if (yw_r < -(VW-7)'(6144))      yw_o = -14'sd6144;
        else if (yw_r > (VW-7)'(6144))  yw_o = 14'sd6144;
        else                            yw_o = yw_r[13:0];

        ht_sum = {1'b0, r_hgt} + (HW+1)'(32768);
        ht_r   = ht_sum[HW:16];
        if (ht_r < {1'b0, jvc_pkg::HEIGHT_LOW})       ht_o = jvc_pkg::HEIGHT_LOW;
        else if (ht_r > {1'b0, jvc_pkg::HEIGHT_HIGH}) ht_o = jvc_pkg::HEIGHT_HIGH;
        else                                          ht_o = ht_r[13:0];
    end

    // state: events and filter updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_raw[i] <= '0;
                r_vel[i] <= '0;
            end
            r_hgt   <= jvc_pkg::HGT_ONE;
            r_htgt  <= jvc_pkg::HEIGHT_LOW;
            r_flags <= '0;
        end else if (i_evt_acc && i_evt_cmd == jvc_pkg::CMD_AXIS) begin
            case (i_evt_num)
                jvc_pkg::AXIS_FWD:  r_raw[0] <= i_evt_val;
                jvc_pkg::AXIS_LAT:  r_raw[1] <= i_evt_val;
                jvc_pkg::AXIS_TURN: r_raw[2] <= i_evt_val;
                default: ;
            endcase
        end else if (i_evt_acc && i_evt_cmd == jvc_pkg::CMD_BUTTON && btn_press) begin
            case (i_evt_num)
                jvc_pkg::BTN_START, jvc_pkg::BTN_STOP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_raw[i] <= '0;
                        r_vel[i] <= '0;
                    end
                    r_hgt <= jvc_pkg::HGT_ONE;
                end
                jvc_pkg::BTN_DOWN: begin
                    if (r_htgt < jvc_pkg::HEIGHT_LOW + jvc_pkg::HEIGHT_STEP)
                        r_htgt <= jvc_pkg::HEIGHT_LOW;
                    else
                        r_htgt <= r_htgt - jvc_pkg::HEIGHT_STEP;
                end
                jvc_pkg::BTN_UP: begin
                    if (r_htgt > jvc_pkg::HEIGHT_HIGH - jvc_pkg::HEIGHT_STEP)
                        r_htgt <= jvc_pkg::HEIGHT_HIGH;
                    else
                        r_htgt <= r_htgt + jvc_pkg::HEIGHT_STEP;
                end
                jvc_pkg::BTN_A: r_flags[0] <= !r_flags[0];
                jvc_pkg::BTN_X: r_flags[1] <= !r_flags[1];
                jvc_pkg::BTN_Y: r_flags[2] <= !r_flags[2];
                jvc_pkg::BTN_B: r_flags[3] <= !r_flags[3];
                default: ;
            endcase
        end else if (i_ctl.op == jvc_pkg::OP_UPD) begin
            case (i_ctl.ch)
                jvc_pkg::CH_FWD:  r_vel[0] <= upd[VW-1:0];
                jvc_pkg::CH_LAT:  r_vel[1] <= upd[VW-1:0];
                jvc_pkg::CH_TURN: r_vel[2] <= upd[VW-1:0];
                default:          r_hgt    <= upd[HW-1:0];
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            jvc_pkg::OP_LOAD: begin
                r_mag <= raw_sel[jvc_pkg::RAW_W-1] ? $unsigned(-raw_sel) : $unsigned(raw_sel);
                // axis is inverted: positive raw gives a negative sample
                r_neg <= !raw_sel[jvc_pkg::RAW_W-1] && (raw_sel != '0);
                case (i_ctl.ch)
                    jvc_pkg::CH_FWD:
                        r_max <= raw_sel[jvc_pkg::RAW_W-1] ? i_cfg.fwd_max : i_cfg.rev_max;
                    jvc_pkg::CH_LAT: r_max <= i_cfg.lat_max;
                    default:         r_max <= i_cfg.turn_max;
                endcase
            end
            jvc_pkg::OP_ZERO: r_s <= '0;
            jvc_pkg::OP_MULA: r_prod <= mul_p;
            jvc_pkg::OP_BIAS: r_x <= {r_prod[31:0], 8'h00} + jvc_pkg::DIV_BIAS;
            // 2^15 = 1 mod 32767: fold high part onto low part
            jvc_pkg::OP_FOLD1: begin
                r_q   <= r_x[jvc_pkg::X_W-1:15];
                r_rem <= jvc_pkg::REM_W'(r_x[jvc_pkg::X_W-1:15]) + jvc_pkg::REM_W'(r_x[14:0]);
            end
            jvc_pkg::OP_FOLD2: begin
                r_q   <= r_q + jvc_pkg::Q_W'(r_rem[jvc_pkg::REM_W-1:15]);
                r_rem <= jvc_pkg::REM_W'(r_rem[jvc_pkg::REM_W-1:15])
                       + jvc_pkg::REM_W'(r_rem[14:0]);
            end
            jvc_pkg::OP_FIX: begin
                if (r_rem >= jvc_pkg::DIV_N) r_q <= r_q + 1'b1;
            end
            jvc_pkg::OP_SIGN: r_s <= r_neg ? -q_s : q_s;
            jvc_pkg::OP_HTGT: r_s <= $signed({1'b0, r_htgt, 16'h0000});
            jvc_pkg::OP_DIFF: r_diff <= {r_s[SW-1], r_s} - {f_sel[SW-1], f_sel};
            jvc_pkg::OP_MULF: r_prod <= mul_p;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.op == jvc_pkg::OP_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == jvc_pkg::OP_OUT && out_free) begin
            r_out_data <= {2'b00, r_flags[3], r_flags[2], r_flags[1], r_flags[0],
                           ht_o, yw_o, lt_o, fw_o};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/joystick_velocity_conditioner_unit.sv
// Events: axis and button events are registered into the state as they are accepted; a tick result
//   is loaded into the output register at the last step, skipping scale and divide for dead-zone axes.
// Throughput: one event per cycle while no tick runs; a new tick is taken only after the previous
//   38-step microprogram on the single shared 32x18 multiplier has finished.
// Reset: synchronous, active low; clears config to defaults, axes, filters, flags,
//   height target to 1.0 and the sequencer; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module joystick_velocity_conditioner_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // input request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [7:0] control_number, [23:8] control_value
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] command

    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // [16:0] forward_velocity, [29:17] lateral_velocity,
                                            // [43:30] yaw_rate, [57:44] height_command,
                                            // [58] flag_a, [59] flag_x, [60] flag_y,
                                            // [61] flag_b, [63:62] zero

    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    jvc_pkg::t_cfg     cfg;
    jvc_pkg::t_uword   ctl;
    jvc_pkg::t_dp_stat stat;
    logic              seq_ready;
    logic              in_acc;
    logic              tick_start;

    // Requests are taken whenever no tick program is running. Events are applied
    // to the state directly; a tick launches the microprogram. A result waiting
    // in the output register does not block new requests - only the program's
    // final step waits for that register to drain.
    assign s_axis_tready = seq_ready;
    assign in_acc        = s_axis_tvalid && seq_ready;
    assign tick_start    = in_acc && (s_axis_tuser == jvc_pkg::CMD_TICK);

    jvc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer: step counter over the control ROM. Per axis channel it runs
    // load, dead-zone test (jumps straight to the filter when inside), multiply,
    // divide by 32767 via two folds and a correction, sign, then the filter
    // update; the height filter and the output step follow.
    jvc_useq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tick_start),
        .i_stat  (stat),
        .o_ready (seq_ready),
        .o_ctl   (ctl)
    );

    // Datapath: axis/filter state, shared multiplier, fold divider, output register.
    jvc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_evt_acc   (in_acc),
        .i_evt_cmd   (s_axis_tuser),
        .i_evt_num   (s_axis_tdata[7:0]),
        .i_evt_val   ($signed(s_axis_tdata[23:8])),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### hw/rtl/jvc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module jvc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // an accepted tick occupies the sequencer for the following cycles
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == jvc_pkg::CMD_TICK
        |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("request taken during tick program");

    // height stays inside its clamp
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[57:44] >= jvc_pkg::HEIGHT_LOW
                       && m_axis_tdata[57:44] <= jvc_pkg::HEIGHT_HIGH)
        else $error("height out of range");

    // forward velocity stays inside its clamp
    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[16:0]) >= -17'sd8192
                       && $signed(m_axis_tdata[16:0]) <= 17'sd32768)
        else $error("forward velocity out of range");

endmodule

bind joystick_velocity_conditioner_unit jvc_checker u_jvc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### sim/joystick_velocity_conditioner_unit_test.sv
`timescale 1ns / 1ps

module joystick_velocity_conditioner_unit_test;

    // Command code the block has no use for; it must be dropped silently.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Cycles with no handshake on either stream before the run is declared hung.
    // The limit covers a tick program plus receiver stalls and settle pauses.
    localparam int QUIET_LIMIT = 4000;
    // Tick program length plus margin; used before register writes and at the end.
    localparam int SETTLE_CYCLES = 45;
    localparam int ITEMS_PER_PHASE = 220;

    // ------------------------------------------------------------------
    // Motion model: own copy of the registers and the filter state. Each
    // accepted request updates it; a tick pushes the packed output word.
    // ------------------------------------------------------------------
    class motion_model;
        logic [14:0] dead_zone;
        logic [15:0] fwd_max, rev_max, lat_max, turn_max;
        logic [16:0] sm_planar, sm_turn, sm_height;

        logic signed [15:0] axis_pos [3];   // forward, lateral, turn
        longint             vel_q20 [3];
        longint             height_q28;
        int                 height_tgt;
        logic [3:0]         flags;          // A, X, Y, B from bit 0 up

        logic [63:0] pending_motion [$];
        int          errors;

        function new();
            errors     = 0;
            dead_zone  = jvc_pkg::RST_DEAD_ZONE;
            fwd_max    = jvc_pkg::RST_FWD_MAX;
            rev_max    = jvc_pkg::RST_REV_MAX;
            lat_max    = jvc_pkg::RST_LAT_MAX;
            turn_max   = jvc_pkg::RST_TURN_MAX;
            sm_planar  = jvc_pkg::RST_SM_PLANAR;
            sm_turn    = jvc_pkg::RST_SM_TURN;
            sm_height  = jvc_pkg::RST_SM_HEIGHT;
            clear_motion();
            height_tgt = 4096;
            flags      = 4'b0000;
        endfunction

        function void clear_motion();
            for (int i = 0; i < 3; i++) begin
                axis_pos[i] = '0;
                vel_q20[i]  = 0;
            end
            height_q28 = longint'(1) << 28;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                jvc_pkg::REG_DEAD_ZONE: dead_zone = value[14:0];
                jvc_pkg::REG_FWD_MAX:   fwd_max   = value[15:0];
                jvc_pkg::REG_REV_MAX:   rev_max   = value[15:0];
                jvc_pkg::REG_LAT_MAX:   lat_max   = value[15:0];
                jvc_pkg::REG_TURN_MAX:  turn_max  = value[15:0];
                jvc_pkg::REG_SM_PLANAR: sm_planar = value[16:0];
                jvc_pkg::REG_SM_TURN:   sm_turn   = value[16:0];
                jvc_pkg::REG_SM_HEIGHT: sm_height = value[16:0];
                default: ;
            endcase
        endfunction

        // floor((x + half) / 2^sh)
        function longint round_down_shift(longint x, int sh);
            return (x + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function longint clip(longint x, longint lo, longint hi);
            return (x < lo) ? lo : ((x > hi) ? hi : x);
        endfunction

        // Stick position -> Q20 speed, inverted, dead zone, per-side scale.
        function longint speed_sample(logic signed [15:0] pos, logic [15:0] pos_max,
                                      logic [15:0] neg_max);
            longint v, mag, q, scale;
            v   = -longint'(pos);
            mag = (v < 0) ? -v : v;
            if (mag <= longint'(dead_zone))
                return 0;
            scale = (v > 0) ? longint'(pos_max) : longint'(neg_max);
            q = (mag * scale * 256 + 16383) / 32767;
            return (v > 0) ? q : -q;
        endfunction

        function longint ema(longint f, longint s, logic [16:0] w);
            longint a;
            a = (w > 17'd65536) ? 65536 : longint'(w);
            return round_down_shift(a * s + (65536 - a) * f, 16);
        endfunction

        function void note_request(logic [1:0] cmd, logic [7:0] num, logic [15:0] val);
            longint fw, lt, yw, ht;
            case (cmd)
                jvc_pkg::CMD_AXIS: begin
                    if (num == jvc_pkg::AXIS_FWD)       axis_pos[0] = val;
                    else if (num == jvc_pkg::AXIS_LAT)  axis_pos[1] = val;
                    else if (num == jvc_pkg::AXIS_TURN) axis_pos[2] = val;
                end
                jvc_pkg::CMD_BUTTON: begin
                    if (val != 16'd0) begin
                        case (num)
                            jvc_pkg::BTN_START, jvc_pkg::BTN_STOP: clear_motion();
                            jvc_pkg::BTN_DOWN:
                                height_tgt = int'(clip(height_tgt - 819, 4096, 12288));
                            jvc_pkg::BTN_UP:
                                height_tgt = int'(clip(height_tgt + 819, 4096, 12288));
                            jvc_pkg::BTN_A: flags[0] = ~flags[0];
                            jvc_pkg::BTN_X: flags[1] = ~flags[1];
                            jvc_pkg::BTN_Y: flags[2] = ~flags[2];
                            jvc_pkg::BTN_B: flags[3] = ~flags[3];
                            default: ;
                        endcase
                    end
                end
                jvc_pkg::CMD_TICK: begin
                    vel_q20[0] = ema(vel_q20[0], speed_sample(axis_pos[0], fwd_max, rev_max),
                                     sm_planar);
                    vel_q20[1] = ema(vel_q20[1], speed_sample(axis_pos[1], lat_max, lat_max),
                                     sm_planar);
                    vel_q20[2] = ema(vel_q20[2], speed_sample(axis_pos[2], turn_max, turn_max),
                                     sm_turn);
                    height_q28 = ema(height_q28, longint'(height_tgt) << 16, sm_height);
                    fw = clip(round_down_shift(vel_q20[0], 8), -8192, 32768);
                    lt = clip(round_down_shift(vel_q20[1], 8), -2458, 2458);
                    yw = clip(round_down_shift(vel_q20[2], 8), -6144, 6144);
                    ht = clip(round_down_shift(height_q28, 16), 4096, 12288);
                    pending_motion.push_back({2'b00, flags, 14'(ht), 14'(yw), 13'(lt),
                                              17'(fw)});
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [63:0] got);
            logic [63:0] want;
            if (pending_motion.size() == 0) begin
                $error("unexpected result 0x%016h", got);
                errors++;
                return;
            end
            want = pending_motion.pop_front();
            compare_field("forward_velocity", want[16:0],  got[16:0]);
            compare_field("lateral_velocity", want[29:17], got[29:17]);
            compare_field("yaw_rate",         want[43:30], got[43:30]);
            compare_field("height_command",   want[57:44], got[57:44]);
            compare_field("flag_a",           want[58],    got[58]);
            compare_field("flag_x",           want[59],    got[59]);
            compare_field("flag_y",           want[60],    got[60]);
            compare_field("flag_b",           want[61],    got[61]);
            compare_field("padding",          want[63:62], got[63:62]);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value.
    // ------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [63:0] m_axis_tdata;
    wire  [31:0] prdata;
    wire         pready;

    joystick_velocity_conditioner_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] control_number, [23:8] control_value
        .s_axis_tuser  (s_axis_tuser),   // [1:0] command
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [16:0] fwd, [29:17] lat, [43:30] yaw,
                                         // [57:44] height, [61:58] flags A,X,Y,B
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    motion_model sb = new();

    int send_idle_pct  = 0;   // chance the sender holds off before a request
    int recv_stall_pct = 0;   // chance the receiver drops tready in a cycle
    int quiet_cycles   = 0;

    // Receiver backpressure, redrawn every cycle.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Monitor: values read here are the ones present at the edge, since the
    // block's own updates land in the NBA region afterwards.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
    end

    // Hang detector.
    initial begin : watchdog
        @(posedge i_clk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("joystick_velocity_conditioner_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One request on the input stream; returns right after it is taken.
    // tvalid stays high into the next call unless a hold-off is drawn.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] num,
                                input logic [15:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, num};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; lands on the pready edge.
    // The bus stays selected so a following write starts its setup cycle at once.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_setting(input logic [31:0] dz, input logic [31:0] fwd,
                                 input logic [31:0] rev, input logic [31:0] lat,
                                 input logic [31:0] turn, input logic [31:0] sp,
                                 input logic [31:0] st, input logic [31:0] sh);
        write_reg(jvc_pkg::REG_DEAD_ZONE, dz);
        write_reg(jvc_pkg::REG_FWD_MAX,   fwd);
        write_reg(jvc_pkg::REG_REV_MAX,   rev);
        write_reg(jvc_pkg::REG_LAT_MAX,   lat);
        write_reg(jvc_pkg::REG_TURN_MAX,  turn);
        write_reg(jvc_pkg::REG_SM_PLANAR, sp);
        write_reg(jvc_pkg::REG_SM_TURN,   st);
        write_reg(jvc_pkg::REG_SM_HEIGHT, sh);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain: no request in flight, every tick answered, then let the
    // microprogram run out before registers are touched.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_motion.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------
    function automatic logic [15:0] nonzero_value();
        logic [15:0] v;
        do v = 16'($urandom); while (v == 16'd0);
        return v;
    endfunction

    // Mix of full deflection, dead-zone edges and anything at all.
    function automatic logic [15:0] pick_axis_value();
        logic [15:0] dz;
        dz = {1'b0, sb.dead_zone};
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h8001;
            3: return 16'd0;
            4: return 16'd0 - dz;
            5: return 16'd0 - dz - 16'd1;
            6: return dz;
            7: return dz + 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly meaningful events and ticks; a tail of ignored numbers,
    // releases and the unused command code.
    task automatic random_request(input int phase);
        int          r, up_pct;
        logic [1:0]  cmd;
        logic [7:0]  num;
        logic [15:0] val;
        // alternate phases lean up or down so the height target reaches both clamps
        up_pct = (phase % 2 == 0) ? 70 : 30;
        r      = $urandom_range(99);
        num    = 8'($urandom);
        val    = 16'($urandom);
        if (r < 35) begin
            cmd = jvc_pkg::CMD_AXIS;
            case ($urandom_range(9))
                0, 1, 2: num = jvc_pkg::AXIS_FWD;
                3, 4, 5: num = jvc_pkg::AXIS_LAT;
                6, 7, 8: num = jvc_pkg::AXIS_TURN;
                default: ;
            endcase
            val = pick_axis_value();
        end else if (r < 60) begin
            cmd = jvc_pkg::CMD_BUTTON;
            r   = $urandom_range(99);
            if (r < 4)
                num = ($urandom_range(1) == 0) ? jvc_pkg::BTN_START : jvc_pkg::BTN_STOP;
            else if (r < 44)
                num = ($urandom_range(99) < up_pct) ? jvc_pkg::BTN_UP : jvc_pkg::BTN_DOWN;
            else if (r < 88) begin
                case ($urandom_range(3))
                    0: num = jvc_pkg::BTN_A;
                    1: num = jvc_pkg::BTN_B;
                    2: num = jvc_pkg::BTN_X;
                    default: num = jvc_pkg::BTN_Y;
                endcase
            end
            val = ($urandom_range(99) < 15) ? 16'd0 : nonzero_value();
        end else if (r < 92) begin
            cmd = jvc_pkg::CMD_TICK;
        end else begin
            cmd = CMD_UNUSED;
        end
        send_request(cmd, num, val);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] sp, st, sh;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset register values, no idling.
        send_request(jvc_pkg::CMD_TICK, 8'd0, 16'd0);                  // everything at rest
        send_request(jvc_pkg::CMD_AXIS, jvc_pkg::AXIS_FWD, 16'h8000);  // inverts to +32768
        send_request(jvc_pkg::CMD_AXIS, jvc_pkg::AXIS_LAT, 16'h7FFF);  // full negative lateral
        send_request(jvc_pkg::CMD_AXIS, jvc_pkg::AXIS_TURN, 16'h8000);
        send_request(jvc_pkg::CMD_TICK, 8'hFF, 16'hFFFF);
        send_request(jvc_pkg::CMD_AXIS, jvc_pkg::AXIS_FWD, 16'h7FFF);  // reverse side scale
        // exactly on dead zone
        send_request(jvc_pkg::CMD_AXIS, jvc_pkg::AXIS_LAT, 16'd0 - 16'd1000);
        send_request(jvc_pkg::CMD_AXIS, jvc_pkg::AXIS_TURN, 16'd1001); // just outside it
        send_request(jvc_pkg::CMD_TICK, 8'd0, 16'd0);
        send_request(jvc_pkg::CMD_BUTTON, jvc_pkg::BTN_UP, 16'd1);
        send_request(jvc_pkg::CMD_BUTTON, jvc_pkg::BTN_UP, 16'h8000);  // any nonzero is a press
        send_request(jvc_pkg::CMD_BUTTON, jvc_pkg::BTN_DOWN, 16'd0);   // release is ignored
        send_request(jvc_pkg::CMD_BUTTON, jvc_pkg::BTN_A, 16'd1);
        send_request(jvc_pkg::CMD_BUTTON, jvc_pkg::BTN_B, 16'h7FFF);
        send_request(jvc_pkg::CMD_BUTTON, jvc_pkg::BTN_X, 16'hFFFF);
        send_request(jvc_pkg::CMD_BUTTON, jvc_pkg::BTN_Y, 16'h5555);
        send_request(jvc_pkg::CMD_BUTTON, 8'd200, 16'd1);              // unknown button
        send_request(jvc_pkg::CMD_AXIS, 8'hFF, 16'd1234);              // unknown axis
        send_request(CMD_UNUSED, 8'hFF, 16'hFFFF);                     // unused command
        send_request(jvc_pkg::CMD_TICK, 8'hAA, 16'hAAAA);
        send_request(jvc_pkg::CMD_BUTTON, jvc_pkg::BTN_STOP, 16'd1);   // clears axes and filters
        send_request(jvc_pkg::CMD_TICK, 8'd0, 16'd0);
        send_request(jvc_pkg::CMD_BUTTON, jvc_pkg::BTN_DOWN, 16'd2);   // steps the target down
        send_request(jvc_pkg::CMD_BUTTON, jvc_pkg::BTN_START, 16'd3);
        send_request(jvc_pkg::CMD_TICK, 8'h55, 16'h5555);

        for (int p = 0; p < 8; p++) begin
            settle();
            case (p)
                0: apply_setting(jvc_pkg::RST_DEAD_ZONE, jvc_pkg::RST_FWD_MAX,
                                 jvc_pkg::RST_REV_MAX, jvc_pkg::RST_LAT_MAX,
                                 jvc_pkg::RST_TURN_MAX, jvc_pkg::RST_SM_PLANAR,
                                 jvc_pkg::RST_SM_TURN, jvc_pkg::RST_SM_HEIGHT);
                // widest dead zone, largest scales, weights past one
                1: apply_setting(32'h7FFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                                 32'h1FFFF, 32'h1FFFF, 32'h1FFFF);
                // nothing passes the scales, filters frozen
                2: apply_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
                // no dead zone, filters follow the sample at once
                3: apply_setting(32'd0, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                                 32'd65536, 32'd65536, 32'd65536);
                default: begin
                    sp = ($urandom_range(1) == 0) ? $urandom_range(65536) : $urandom;
                    st = ($urandom_range(1) == 0) ? $urandom_range(65536) : $urandom;
                    sh = ($urandom_range(1) == 0) ? $urandom_range(65536) : $urandom;
                    // bits above each register's width ride along and must be dropped
                    apply_setting(($urandom_range(1) == 0) ? $urandom_range(4000) : $urandom,
                                  $urandom, $urandom, $urandom, $urandom, sp, st, sh);
                end
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_request(p);
        end

        settle();
        if (sb.errors == 0 && sb.pending_motion.size() == 0)
            $display("joystick_velocity_conditioner_unit verification clean");
        else
            $display("joystick_velocity_conditioner_unit verification failed");
        $finish;
    end

endmodule
